[src/array_priority_queue_core_assert.svh]
// Assertion macros shared by the checker of array_priority_queue_core.
// No dependencies; included by the checker module.
`ifndef ARRAY_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define ARRAY_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define APQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define APQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/apq_pkg.sv]
// Package for the array priority queue: opcodes, status codes, FSM states
// and field widths. No dependencies.
package apq_pkg;

  // Field widths of the request and result
  localparam int OP_W        = 2;
  localparam int ELEM_W      = 32;
  localparam int PRIO_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int CNT_OUT_W   = 4;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_PEEK   = 2'd1,
    OP_DELETE = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } apq_state_t;

endpackage

[src/array_priority_queue_core.sv]
// Channel | dir | tdata (low bit up)                      | tuser
// in_     | in  | element[31:0], priority_req[39:32]      | opcode[1:0]
// out_    | out | element[31:0], priority[39:32],          | status[1:0]
//         |     | count[43:40], zero pad[47:44]            |
//
// Insert, unused opcode, full or empty: from S_IDLE through S_RESULT back to S_IDLE.
// Peek scans in S_SCAN: the single RAM read port scans one slot a cycle.
// Delete adds S_SHIFT to peek, which moves each slot after the removed one down by one.
// Synchronous active-low reset empties the queue; RAM contents are not cleared.
// A new request is taken while an earlier result waits on out_tready.
// Depends on apq_pkg and apq_ram.
module array_priority_queue_core #(
  parameter int CAPACITY      = 8,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // element[31:0], priority_req[39:32]
  input  logic [apq_pkg::IN_TDATA_W-1:0]   in_tdata,
  // opcode[1:0]
  input  logic [apq_pkg::OP_W-1:0]         in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // element[31:0], priority[39:32], count[43:40], zero pad[47:44]
  output logic [apq_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // status[1:0]
  output logic [apq_pkg::STATUS_W-1:0]     out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready
);
  import apq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (PRIORITY_BITS < PRIO_W) ? PRIORITY_BITS : PRIO_W;
  localparam int EW = ELEM_W + PW;
  localparam int PAD_W = OUT_TDATA_W - ELEM_W - PRIO_W - CNT_OUT_W;

  // control state
  apq_state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          out_valid_r, out_valid_nxt;

  // payload registers
  logic              del_r, del_nxt;
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]     best_idx_r, best_idx_nxt;
  logic [PW-1:0]     best_prio_r, best_prio_nxt;
  logic [ELEM_W-1:0] best_elem_r, best_elem_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [ELEM_W-1:0] res_elem_r, res_elem_nxt;
  logic [PW-1:0]     res_prio_r, res_prio_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [ELEM_W-1:0] out_elem_r, out_elem_nxt;
  logic [PRIO_W-1:0] out_prio_r, out_prio_nxt;
  logic [CNT_OUT_W-1:0] out_count_r, out_count_nxt;

  // RAM side
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [ELEM_W-1:0] in_elem;
  logic [PRIO_W-1:0] in_prio;
  logic [PW-1:0]     rd_prio;
  logic [ELEM_W-1:0] rd_elem;
  logic              issue;
  logic              last_rd;

  assign in_elem = in_tdata[ELEM_W-1:0];
  assign in_prio = in_tdata[ELEM_W +: PRIO_W];
  assign rd_elem = ram_rdata[ELEM_W-1:0];
  assign rd_prio = ram_rdata[ELEM_W +: PW];
  assign issue   = (ptr_r < count_r);
  assign last_rd = ((CW'(rd_idx_r) + CW'(1)) == count_r);

  // slot store: {priority, element} per entry
  apq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    del_r        <= del_nxt;
    rd_idx_r     <= rd_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_prio_r  <= best_prio_nxt;
    best_elem_r  <= best_elem_nxt;
    res_status_r <= res_status_nxt;
    res_elem_r   <= res_elem_nxt;
    res_prio_r   <= res_prio_nxt;
    out_status_r <= out_status_nxt;
    out_elem_r   <= out_elem_nxt;
    out_prio_r   <= out_prio_nxt;
    out_count_r  <= out_count_nxt;
  end

  // next state, RAM control and results
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    rd_pend_nxt    = 1'b0;
    out_valid_nxt  = out_valid_r;
    del_nxt        = del_r;
    rd_idx_nxt     = rd_idx_r;
    best_idx_nxt   = best_idx_r;
    best_prio_nxt  = best_prio_r;
    best_elem_nxt  = best_elem_r;
    res_status_nxt = res_status_r;
    res_elem_nxt   = res_elem_r;
    res_prio_nxt   = res_prio_r;
    out_status_nxt = out_status_r;
    out_elem_nxt   = out_elem_r;
    out_prio_nxt   = out_prio_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;
    in_tready      = 1'b0;

    // output register drains on a taken result
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        in_tready    = 1'b1;
        res_elem_nxt = '0;
        res_prio_nxt = '0;
        if (in_tvalid) begin
          unique case (opcode_t'(in_tuser))
            OP_INSERT: begin
              state_nxt = S_RESULT;
              if (count_r == CW'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
              end else begin
                res_status_nxt = ST_OK;
                ram_we         = 1'b1;
                ram_waddr      = count_r[AW-1:0];
                ram_wdata      = {in_prio[PW-1:0], in_elem};
                count_nxt      = count_r + CW'(1);
              end
            end
            OP_PEEK, OP_DELETE: begin
              del_nxt = (opcode_t'(in_tuser) == OP_DELETE);
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_RESULT;
              end else begin
                ptr_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              // unused opcode: no change, plain ok
              res_status_nxt = ST_OK;
              state_nxt      = S_RESULT;
            end
          endcase
        end
      end

      S_SCAN: begin
        // read one slot a cycle, compare the slot read last cycle
        if (issue) begin
          ram_raddr   = ptr_r[AW-1:0];
          rd_idx_nxt  = ptr_r[AW-1:0];
          ptr_nxt     = ptr_r + CW'(1);
          rd_pend_nxt = 1'b1;
        end
        if (rd_pend_r) begin
          // strict compare keeps the earliest of equal priorities
          if ((rd_idx_r == '0) || (rd_prio > best_prio_r)) begin
            best_idx_nxt  = rd_idx_r;
            best_prio_nxt = rd_prio;
            best_elem_nxt = rd_elem;
          end
          if (last_rd) begin
            if (del_r) begin
              ptr_nxt   = CW'(best_idx_nxt) + CW'(1);
              state_nxt = S_SHIFT;
            end else begin
              res_status_nxt = ST_OK;
              res_elem_nxt   = '0;
              res_prio_nxt   = best_prio_nxt;
              state_nxt      = S_RESULT;
            end
          end
        end
      end

      S_SHIFT: begin
        // read slot j+1, write it to slot j in the next cycle
        if (issue) begin
          ram_raddr   = ptr_r[AW-1:0];
          rd_idx_nxt  = ptr_r[AW-1:0];
          ptr_nxt     = ptr_r + CW'(1);
          rd_pend_nxt = 1'b1;
        end
        if (rd_pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_r - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (!issue && !rd_pend_r) begin
          count_nxt      = count_r - CW'(1);
          res_status_nxt = ST_OK;
          res_elem_nxt   = best_elem_r;
          res_prio_nxt   = best_prio_r;
          state_nxt      = S_RESULT;
        end
      end

      S_RESULT: begin
        // wait for the output register to be free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_elem_nxt   = res_elem_r;
          out_prio_nxt   = PRIO_W'(res_prio_r);
          out_count_nxt  = CNT_OUT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_count_r, out_prio_r, out_elem_r};

endmodule

[src/apq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module apq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/apq_checker.sv]
// Port-level checker for array_priority_queue_core, bound to the top level.
// Depends on apq_pkg and array_priority_queue_core_assert.svh.
`include "array_priority_queue_core_assert.svh"

module apq_checker #(
  parameter int CAPACITY = 8
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic [apq_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [apq_pkg::STATUS_W-1:0]    out_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready
);
  import apq_pkg::*;

  logic [ELEM_W-1:0]    o_elem;
  logic [PRIO_W-1:0]    o_prio;
  logic [CNT_OUT_W-1:0] o_count;

  assign o_elem  = out_tdata[ELEM_W-1:0];
  assign o_prio  = out_tdata[ELEM_W +: PRIO_W];
  assign o_count = out_tdata[ELEM_W + PRIO_W +: CNT_OUT_W];

  // a stalled result holds
  `APQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // full is only reported with the queue at capacity and no payload
  `APQ_ASSERT_NOW(a_full_count, clk, rst_n, out_tvalid && (out_tuser == ST_FULL),
    (o_count == CNT_OUT_W'(CAPACITY)) && (o_elem == '0) && (o_prio == '0),
    "full result with wrong count or payload")

  // empty is only reported with nothing held and no payload
  `APQ_ASSERT_NOW(a_empty_count, clk, rst_n, out_tvalid && (out_tuser == ST_EMPTY),
    (o_count == '0) && (o_elem == '0) && (o_prio == '0),
    "empty result with wrong count or payload")

  // status code stays within its defined set
  `APQ_ASSERT_NOW(a_status_code, clk, rst_n, out_tvalid,
    (out_tuser == ST_OK) || (out_tuser == ST_FULL) || (out_tuser == ST_EMPTY),
    "undefined status code")

endmodule

bind array_priority_queue_core apq_checker #(.CAPACITY(CAPACITY)) u_apq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

[test/tb.sv]
// Self-checking bench for array_priority_queue_core: directed and random insert, peek and
// delete requests, checked against an in-bench queue predictor with random stalls on both sides.
// Depends on apq_pkg and the RTL of array_priority_queue_core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import apq_pkg::*;

  localparam int CAPACITY      = 8;
  localparam int PRIORITY_BITS = 8;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic [PRIO_W-1:0] prio;
  } pq_entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [ELEM_W-1:0]    element;
    logic [PRIO_W-1:0]    prio;
    logic [CNT_OUT_W-1:0] count;
  } pq_result_t;

  // Predicts every result from accepted requests and checks results in order
  class priority_queue_model;
    pq_entry_t  held[$];
    pq_result_t expected_results[$];
    int         mismatches = 0;

    function int pending();
      return expected_results.size();
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [ELEM_W-1:0] elem,
                               logic [PRIO_W-1:0] prio);
      pq_result_t r;
      pq_entry_t  e;
      int         best;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_INSERT: begin
          if (held.size() >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            e.element = elem;
            e.prio    = prio;
            held.push_back(e);
          end
        end
        OP_PEEK, OP_DELETE: begin
          if (held.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // first slot wins a tie, i.e. the earliest insert
            best = 0;
            foreach (held[i]) if (held[i].prio > held[best].prio) best = i;
            r.prio = held[best].prio;
            if (op == OP_DELETE) begin
              r.element = held[best].element;
              held.delete(best);
            end
          end
        end
        default: ;  // unused opcode: queue untouched
      endcase
      r.count = CNT_OUT_W'(held.size());
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [ELEM_W-1:0] elem,
                               logic [PRIO_W-1:0] prio, logic [CNT_OUT_W-1:0] cnt,
                               logic [3:0] pad);
      pq_result_t exp;
      if (expected_results.size() == 0) begin
        flag($sformatf({"result with no request outstanding: ",
                        "status %0d element %h prio %0d count %0d"},
                       st, elem, prio, cnt));
        return;
      end
      exp = expected_results.pop_front();
      if (st !== exp.status)
        flag($sformatf("status: expected %0d, got %0d", exp.status, st));
      if (elem !== exp.element)
        flag($sformatf("element: expected %h, got %h", exp.element, elem));
      if (prio !== exp.prio)
        flag($sformatf("priority: expected %0d, got %0d", exp.prio, prio));
      if (cnt !== exp.count)
        flag($sformatf("count: expected %0d, got %0d", exp.count, cnt));
      if (pad !== 4'd0)
        flag($sformatf("tdata pad: expected 0, got %h", pad));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]        in_tuser = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;

  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  int unsigned cycles = 0;

  priority_queue_model model = new();

  array_priority_queue_core #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Handshake monitor: results first, then the newly accepted request
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      model.check_result(out_tuser, out_tdata[31:0], out_tdata[39:32], out_tdata[43:40],
                         out_tdata[47:44]);
    if (rst_n && in_tvalid && in_tready)
      model.note_request(in_tuser, in_tdata[31:0], in_tdata[39:32]);
  end

  // Result side: random back-pressure before each result while recv_idle is set
  initial begin
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = recv_idle ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Present one request, after a random gap while send_idle is set, and hold it until taken
  task automatic send_request(logic [OP_W-1:0] op, logic [ELEM_W-1:0] elem,
                              logic [PRIO_W-1:0] prio);
    int gap;
    gap = send_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {prio, elem};
    in_tuser  <= op;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending until every outstanding result is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (model.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Priorities: crowded low values for ties, the extremes, or anything
  function automatic logic [PRIO_W-1:0] draw_prio();
    case ($urandom_range(0, 3))
      0:       return PRIO_W'($urandom_range(0, 3));
      1:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return PRIO_W'($urandom);
    endcase
  endfunction

  initial begin
    int               fill_bias;
    int               roll;
    int               real_ops;
    logic [OP_W-1:0]  op;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty cases, fill with extremes and ties, overflow, then empty it
    send_request(OP_PEEK,   32'h0000_0000, 8'h00);
    send_request(OP_DELETE, 32'h0000_0000, 8'h00);
    send_request(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF);
    send_request(OP_INSERT, 32'h8000_0000, 8'h00);
    send_request(OP_INSERT, 32'h7FFF_FFFF, 8'hFF);
    send_request(OP_INSERT, 32'h0000_0000, 8'h80);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 8'hFF);
    send_request(OP_INSERT, 32'h1234_5678, 8'h01);
    send_request(OP_INSERT, 32'hA5A5_A5A5, 8'h00);
    send_request(OP_INSERT, 32'h5A5A_5A5A, 8'h7F);
    send_request(OP_INSERT, 32'hDEAD_BEEF, 8'hFF);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 8'hFF);
    send_request(OP_UNUSED, 32'h0000_0000, 8'h00);
    send_request(OP_PEEK,   32'hFFFF_FFFF, 8'hFF);
    repeat (CAPACITY) send_request(OP_DELETE, 32'hFFFF_FFFF, 8'hFF);
    send_request(OP_DELETE, 32'h0000_0000, 8'h00);
    wait_drained();

    // Random phases alternating between filling and draining
    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 7) wait_drained();
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      fill_bias = ph[0] ? 25 : 55;
      real_ops  = 0;
      while (real_ops < 36) begin
        roll = $urandom_range(0, 99);
        if (roll < 4)                    op = OP_UNUSED;
        else if (roll < 18)              op = OP_PEEK;
        else if (roll < 18 + fill_bias)  op = OP_INSERT;
        else                             op = OP_DELETE;
        send_request(op, $urandom, draw_prio());
        if (op != OP_UNUSED) real_ops++;
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (model.mismatches == 0 && model.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/apq_pkg.sv
src/apq_ram.sv
src/array_priority_queue_core.sv
src/apq_checker.sv
test/tb.sv
